[rtl/reonm_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the one-norm relative error block.
// No dependencies; used by reonm_ctrl, reonm_dp and the top level.
package reonm_pkg;

    localparam int SUM_W      = 48;
    localparam int OUT_W      = 32;
    localparam int FRAC_BITS  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int STEP_W     = $clog2(OUT_W);
    localparam int MODE_W     = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TRIANGLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS  = 2'd2;

    // Triangle selection codes; the unused code behaves as the full matrix.
    localparam logic [MODE_W-1:0] TRI_FULL  = 2'd0;
    localparam logic [MODE_W-1:0] TRI_LOWER = 2'd1;
    localparam logic [MODE_W-1:0] TRI_UPPER = 2'd2;

    typedef struct packed {
        logic load;
        logic use_elem;
        logic col_end;
        logic mat_end;
        logic clear;
        logic div_load;
        logic div_check;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic mat_done;
        logic out_busy;
    } t_sts;

endpackage

[rtl/reonm_ctrl.sv]
`timescale 1ns / 1ps
// Controller: configuration registers, row and column counters, and the
// sequencer for draining, dividing and loading the result. Uses reonm_pkg.
module reonm_ctrl import reonm_pkg::*; #(
    parameter int MAX_DIM = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_sts                  i_sts,
    output t_cmd                  o_cmd
);

    localparam int CNT_W  = $clog2(MAX_DIM);
    localparam int LIM_W  = $clog2(MAX_DIM + 1);
    localparam int CMP_W  = (LIM_W > CFG_DATA_W) ? LIM_W : CFG_DATA_W;

    localparam logic [2:0] S_RUN   = 3'd0;
    localparam logic [2:0] S_DRAIN = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(OUT_W - 1);

    logic [2:0]            r_state, n_state;
    logic [STEP_W-1:0]     r_step, n_step;
    logic [MODE_W-1:0]     r_tri;
    logic [CFG_DATA_W-1:0] r_row_total;
    logic [CFG_DATA_W-1:0] r_col_total;
    logic [CNT_W-1:0]      r_row;
    logic [CNT_W-1:0]      r_col;

    logic [CMP_W-1:0] row_cfg, col_cfg, row_lim, col_lim;
    logic [CNT_W-1:0] row_last, col_last;
    logic             in_acc, in_tri, col_end, mat_end, cfg_hit;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_RUN);
    assign in_acc      = i_in_valid && (r_state == S_RUN);
    assign cfg_hit     = i_cfg_valid && ((i_cfg_index == REG_TRIANGLE) ||
                         (i_cfg_index == REG_ROWS) || (i_cfg_index == REG_COLUMNS));

    // A size of zero acts as one, a size above MAX_DIM as MAX_DIM.
    always_comb begin
        row_cfg  = CMP_W'(r_row_total);
        col_cfg  = CMP_W'(r_col_total);
        row_lim  = (row_cfg == '0) ? CMP_W'(1) :
                   (row_cfg > CMP_W'(MAX_DIM)) ? CMP_W'(MAX_DIM) : row_cfg;
        col_lim  = (col_cfg == '0) ? CMP_W'(1) :
                   (col_cfg > CMP_W'(MAX_DIM)) ? CMP_W'(MAX_DIM) : col_cfg;
        row_last = CNT_W'(row_lim - CMP_W'(1));
        col_last = CNT_W'(col_lim - CMP_W'(1));
    end

    always_comb begin
        case (r_tri)
            TRI_LOWER: in_tri = (r_row >= r_col);
            TRI_UPPER: in_tri = (r_row < r_col);
            default:   in_tri = 1'b1;
        endcase
        col_end = (r_row == row_last);
        mat_end = col_end && (r_col == col_last);
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = in_acc;
        o_cmd.use_elem = in_tri;
        o_cmd.col_end  = col_end;
        o_cmd.mat_end  = mat_end;
        o_cmd.clear    = cfg_hit;
        n_state        = r_state;
        n_step         = r_step;
        case (r_state)
            S_RUN: begin
                if (in_acc && mat_end) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_sts.mat_done) begin
                    o_cmd.div_load = 1'b1;
                    n_state        = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.div_check = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_step == STEP_LAST) begin
                    n_step  = '0;
                    n_state = S_DONE;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_RUN;
                end
            end
            default: begin
                n_state = S_RUN;
                n_step  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_step      <= '0;
            r_tri       <= TRI_FULL;
            r_row_total <= CFG_DATA_W'(1);
            r_col_total <= CFG_DATA_W'(1);
            r_row       <= '0;
            r_col       <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_TRIANGLE: r_tri       <= i_cfg_data[MODE_W-1:0];
                    REG_ROWS:     r_row_total <= i_cfg_data;
                    REG_COLUMNS:  r_col_total <= i_cfg_data;
                    default:      ;
                endcase
            end
            if (cfg_hit) begin
                r_row <= '0;
                r_col <= '0;
            end else if (in_acc) begin
                if (col_end) begin
                    r_row <= '0;
                    r_col <= mat_end ? '0 : r_col + CNT_W'(1);
                end else begin
                    r_row <= r_row + CNT_W'(1);
                end
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_row <= row_last))
        else $error("row counter beyond configured row count");

    a_step_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_DIV) |-> (r_step == '0))
        else $error("division step counter not at zero outside division");

    a_drain_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN && i_sts.mat_done) |=> (r_state == S_CHECK))
        else $error("matrix end seen but division not started");
`endif

endmodule

[rtl/reonm_dp.sv]
`timescale 1ns / 1ps
// Datapath: magnitude and difference stages, saturating column sums and
// maxima, a restoring divider and the output register. Uses reonm_pkg.
module reonm_dp import reonm_pkg::*; #(
    parameter int VALUE_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic signed [VALUE_BITS-1:0] i_a_value,
    input  logic signed [VALUE_BITS-1:0] i_b_value,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [OUT_W-1:0]             o_error_ratio,
    output logic                         o_zero_denominator,
    input  t_cmd                         i_cmd,
    output t_sts                         o_sts
);

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                                 input logic [SUM_W-1:0] x);
        logic [SUM_W:0] t;
        t = {1'b0, s} + {1'b0, x};
        return t[SUM_W] ? {SUM_W{1'b1}} : t[SUM_W-1:0];
    endfunction

    // Stage 1: magnitudes.
    logic                  r_s1_valid, r_s1_use, r_s1_col_end, r_s1_mat_end;
    logic [VALUE_BITS-1:0] r_mag_a, r_mag_b;
    // Stage 2: terms to add.
    logic                  r_s2_valid, r_s2_col_end, r_s2_mat_end;
    logic [SUM_W-1:0]      r_add_a, r_add_d;
    // Stage 3: running sums.
    logic [SUM_W-1:0]      r_col_a, r_col_d, r_max_a, r_max_d;
    // Divider.
    logic [SUM_W-1:0]      r_div_rem, r_div_a;
    logic [OUT_W-1:0]      r_div_low, r_quot;
    logic                  r_zero, r_ovf;
    // Output register.
    logic                  r_out_valid;
    logic [OUT_W-1:0]      r_ratio;
    logic                  r_flag;

    logic [VALUE_BITS-1:0] raw_a, raw_b, mag_a, mag_b, diff;
    logic [SUM_W-1:0]      sum_a, sum_d, top_a, top_d;
    logic [SUM_W:0]        shifted, trial;
    logic                  fits;

    always_comb begin
        raw_a = i_a_value;
        raw_b = i_b_value;
        mag_a = raw_a[VALUE_BITS-1] ? (~raw_a + VALUE_BITS'(1)) : raw_a;
        mag_b = raw_b[VALUE_BITS-1] ? (~raw_b + VALUE_BITS'(1)) : raw_b;
        diff  = (r_mag_a >= r_mag_b) ? (r_mag_a - r_mag_b) : (r_mag_b - r_mag_a);

        sum_a = sat_add(r_col_a, r_add_a);
        sum_d = sat_add(r_col_d, r_add_d);
        top_a = (sum_a > r_max_a) ? sum_a : r_max_a;
        top_d = (sum_d > r_max_d) ? sum_d : r_max_d;

        // One quotient bit per step; the remainder stays below the divisor.
        shifted = {r_div_rem, r_div_low[OUT_W-1]};
        trial   = shifted - {1'b0, r_div_a};
        fits    = (shifted >= {1'b0, r_div_a});
    end

    assign o_sts.mat_done  = r_s2_valid && r_s2_mat_end;
    assign o_sts.out_busy  = r_out_valid;
    assign o_out_valid        = r_out_valid;
    assign o_error_ratio      = r_ratio;
    assign o_zero_denominator = r_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_col_a     <= '0;
            r_col_d     <= '0;
            r_max_a     <= '0;
            r_max_d     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_s1_valid <= 1'b0;
                r_s2_valid <= 1'b0;
                r_col_a    <= '0;
                r_col_d    <= '0;
                r_max_a    <= '0;
                r_max_d    <= '0;
            end else begin
                r_s1_valid <= i_cmd.load;
                r_s2_valid <= r_s1_valid;
                if (r_s2_valid) begin
                    if (r_s2_col_end) begin
                        r_col_a <= '0;
                        r_col_d <= '0;
                        r_max_a <= r_s2_mat_end ? '0 : top_a;
                        r_max_d <= r_s2_mat_end ? '0 : top_d;
                    end else begin
                        r_col_a <= sum_a;
                        r_col_d <= sum_d;
                    end
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag_a      <= mag_a;
            r_mag_b      <= mag_b;
            r_s1_use     <= i_cmd.use_elem;
            r_s1_col_end <= i_cmd.col_end;
            r_s1_mat_end <= i_cmd.mat_end;
        end
        if (r_s1_valid) begin
            r_add_a      <= r_s1_use ? SUM_W'(r_mag_a) : '0;
            r_add_d      <= r_s1_use ? SUM_W'(diff) : '0;
            r_s2_col_end <= r_s1_col_end;
            r_s2_mat_end <= r_s1_mat_end;
        end
        // The dividend is max_diff shifted up by the fraction bits.
        if (i_cmd.div_load) begin
            r_div_a   <= top_a;
            r_div_rem <= SUM_W'(top_d[SUM_W-1:FRAC_BITS]);
            r_div_low <= OUT_W'({top_d[FRAC_BITS-1:0], {FRAC_BITS{1'b0}}});
        end else if (i_cmd.div_step) begin
            r_div_rem <= fits ? trial[SUM_W-1:0] : shifted[SUM_W-1:0];
            r_div_low <= {r_div_low[OUT_W-2:0], 1'b0};
            r_quot    <= {r_quot[OUT_W-2:0], fits};
        end
        // The quotient needs more than OUT_W bits when the high part of the
        // dividend already reaches the divisor.
        if (i_cmd.div_check) begin
            r_zero <= (r_div_a == '0);
            r_ovf  <= (r_div_rem >= r_div_a);
        end
        if (i_cmd.out_load) begin
            r_ratio <= (r_zero || r_ovf) ? {OUT_W{1'b1}} : r_quot;
            r_flag  <= r_zero;
        end
    end

`ifndef NO_ASSERTIONS
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !r_out_valid)
        else $error("result loaded over a word not yet taken");

    a_div_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_load |-> (r_s2_valid && r_s2_mat_end))
        else $error("division started before the last element was summed");

    a_stage_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !i_cmd.clear) |=> r_s2_valid)
        else $error("element lost between pipeline stages");
`endif

endmodule

[rtl/relative_error_one_norm.sv]
`timescale 1ns / 1ps
// The result word follows the last element of a matrix through the second
// pipeline stage, summing with divider load, a check state, 32 divide steps and
// the output register load.
// Throughput: one element per cycle within a matrix; input stalls at each matrix
// end while the restoring divider runs, and longer if the previous result word
// has not been taken yet.
// Reset is synchronous and active low: sizes return to one, triangle mode to full.
module relative_error_one_norm import reonm_pkg::*; #(
    parameter int MAX_DIM    = 1024,
    parameter int VALUE_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [VALUE_BITS-1:0] i_a_value,
    input  logic signed [VALUE_BITS-1:0] i_b_value,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [OUT_W-1:0]             o_error_ratio,
    output logic                         o_zero_denominator,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    reonm_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    reonm_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_a_value          (i_a_value),
        .i_b_value          (i_b_value),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_error_ratio      (o_error_ratio),
        .o_zero_denominator (o_zero_denominator),
        .i_cmd              (cmd),
        .o_sts              (sts)
    );

endmodule

[tb/tb_relative_error_one_norm.sv]
`timescale 1ns / 1ps
// Self-checking testbench for relative_error_one_norm: streams paired A/B words,
// predicts each one-norm ratio word and checks it against the block's output.
// Depends on reonm_pkg and the block's RTL; reads no files.
module tb_relative_error_one_norm;
    import reonm_pkg::*;

    localparam int VALUE_BITS   = 32;
    localparam int MAX_DIM      = 1024;
    localparam int DRAIN_CYCLES = 48;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int MAX_REPORTS  = 40;
    localparam logic [63:0] SUM_CEIL = (64'd1 << SUM_W) - 64'd1;
    localparam logic [MODE_W-1:0]    TRI_SPARE  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [OUT_W-1:0] ratio;
        logic             zero_den;
    } t_ratio_word;

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         i_in_valid  = 1'b0;
    logic                         o_in_stall;
    logic signed [VALUE_BITS-1:0] i_a_value   = '0;
    logic signed [VALUE_BITS-1:0] i_b_value   = '0;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    logic [OUT_W-1:0]             o_error_ratio;
    logic                         o_zero_denominator;
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic [CFG_IDX_W-1:0]         i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]        i_cfg_data  = '0;

    // Predictor copy of the configuration and the running sums.
    logic [MODE_W-1:0]     tri_mode = TRI_FULL;
    logic [CFG_DATA_W-1:0] rows_cfg = 11'd1;
    logic [CFG_DATA_W-1:0] cols_cfg = 11'd1;
    int unsigned           cur_row  = 0;
    int unsigned           cur_col  = 0;
    logic [63:0]           col_abs_sum   = '0;
    logic [63:0]           col_diff_sum  = '0;
    logic [63:0]           peak_abs_sum  = '0;
    logic [63:0]           peak_diff_sum = '0;
    t_ratio_word           pending_ratios[$];

    int send_pct    = 0;
    int stall_pct   = 0;
    int err_count   = 0;
    int cycle_count = 0;
    int hold_left   = 0;
    bit hold_req    = 1'b0;

    relative_error_one_norm #(
        .MAX_DIM    (MAX_DIM),
        .VALUE_BITS (VALUE_BITS)
    ) u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_a_value          (i_a_value),
        .i_b_value          (i_b_value),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_error_ratio      (o_error_ratio),
        .o_zero_denominator (o_zero_denominator),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Output stall: random, except during a requested long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_ratio
        t_ratio_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_ratios.size() == 0) begin
                if (err_count < MAX_REPORTS)
                    $display("%0t: unexpected word ratio %h zero_den %b", $time,
                             o_error_ratio, o_zero_denominator);
                err_count++;
            end else begin
                want = pending_ratios.pop_front();
                if (o_error_ratio !== want.ratio) begin
                    if (err_count < MAX_REPORTS)
                        $display("%0t: error_ratio expected %h, actual %h", $time,
                                 want.ratio, o_error_ratio);
                    err_count++;
                end
                if (o_zero_denominator !== want.zero_den) begin
                    if (err_count < MAX_REPORTS)
                        $display("%0t: zero_denominator expected %b, actual %b", $time,
                                 want.zero_den, o_zero_denominator);
                    err_count++;
                end
            end
        end
    end

    function automatic int unsigned eff_dim(logic [CFG_DATA_W-1:0] v);
        if (v == '0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    function automatic logic [63:0] abs_q16(logic [VALUE_BITS-1:0] v);
        logic [63:0] wide;
        wide = {{(64-VALUE_BITS){v[VALUE_BITS-1]}}, v};
        if (v[VALUE_BITS-1]) wide = -wide;
        return wide;
    endfunction

    function automatic logic [63:0] sum_sat(logic [63:0] s, logic [63:0] x);
        logic [63:0] r;
        r = s + x;
        return (r > SUM_CEIL) ? SUM_CEIL : r;
    endfunction

    function automatic bit in_triangle(int unsigned row, int unsigned col);
        case (tri_mode)
            TRI_LOWER: return row >= col;
            TRI_UPPER: return row < col;
            default:   return 1'b1;
        endcase
    endfunction

    function automatic void clear_norm_state();
        cur_row       = 0;
        cur_col       = 0;
        col_abs_sum   = '0;
        col_diff_sum  = '0;
        peak_abs_sum  = '0;
        peak_diff_sum = '0;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_TRIANGLE: tri_mode = data[MODE_W-1:0];
            REG_ROWS:     rows_cfg = data;
            REG_COLUMNS:  cols_cfg = data;
            default:      return;
        endcase
        clear_norm_state();
    endfunction

    // Adds one element pair to the column sums; at the end of the matrix it
    // queues the expected ratio word.
    function automatic void accumulate_norms(logic [31:0] a, logic [31:0] b);
        logic [63:0] mag_a;
        logic [63:0] mag_b;
        logic [63:0] diff;
        logic [63:0] quo;
        logic [63:0] rem;
        logic [63:0] frac;
        t_ratio_word word;
        if (in_triangle(cur_row, cur_col)) begin
            mag_a = abs_q16(a);
            mag_b = abs_q16(b);
            diff = (mag_a >= mag_b) ? mag_a - mag_b : mag_b - mag_a;
            col_abs_sum  = sum_sat(col_abs_sum, mag_a);
            col_diff_sum = sum_sat(col_diff_sum, diff);
        end
        if (cur_row + 1 < eff_dim(rows_cfg)) begin
            cur_row++;
            return;
        end
        if (col_abs_sum > peak_abs_sum) peak_abs_sum = col_abs_sum;
        if (col_diff_sum > peak_diff_sum) peak_diff_sum = col_diff_sum;
        col_abs_sum  = '0;
        col_diff_sum = '0;
        cur_row      = 0;
        if (cur_col + 1 < eff_dim(cols_cfg)) begin
            cur_col++;
            return;
        end
        if (peak_abs_sum == '0) begin
            word.ratio    = '1;
            word.zero_den = 1'b1;
        end else begin
            quo = peak_diff_sum / peak_abs_sum;
            rem = peak_diff_sum % peak_abs_sum;
            word.zero_den = 1'b0;
            if (quo >= 64'd65536) begin
                word.ratio = '1;
            end else begin
                frac = (rem << FRAC_BITS) / peak_abs_sum;
                word.ratio = {quo[15:0], frac[15:0]};
            end
        end
        pending_ratios.push_back(word);
        clear_norm_state();
    endfunction

    function automatic int unsigned elems_per_matrix();
        return eff_dim(rows_cfg) * eff_dim(cols_cfg);
    endfunction

    function automatic logic [31:0] corner_word();
        case ($urandom_range(0, 6))
            0:       return 32'h0000_0000;
            1:       return 32'h0000_0001;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'h8000_0000;
            5:       return 32'h0001_0000;
            default: return 32'hFFFF_0000;
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_dim();
        if ($urandom_range(0, 19) < 16) return 11'($urandom_range(0, 6));
        return 11'($urandom_range(7, 24));
    endfunction

    // Valid stays high from one word to the next unless a gap is drawn.
    task automatic send_elem(input logic [31:0] a, input logic [31:0] b);
        if ($urandom_range(0, 99) < send_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_pct);
        end
        i_in_valid <= 1'b1;
        i_a_value  <= a;
        i_b_value  <= b;
        do @(posedge i_clk); while (o_in_stall);
        accumulate_norms(a, b);
    endtask

    task automatic send_matrix(input int unsigned count, input int flavor);
        logic [31:0] a;
        logic [31:0] b;
        repeat (count) begin
            case (flavor)
                1: begin
                    a = $urandom;
                    b = a + 32'($urandom_range(0, 1023)) - 32'd512;
                end
                2: begin
                    a = '0;
                    b = $urandom;
                end
                3: begin
                    a = 32'($urandom_range(0, 15)) - 32'd8;
                    b = $urandom;
                end
                4: begin
                    a = corner_word();
                    b = corner_word();
                end
                default: begin
                    a = $urandom;
                    b = $urandom;
                end
            endcase
            send_elem(a, b);
        end
    endtask

    function automatic int pick_flavor();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 0;
            4, 5:       return 1;
            6:          return 2;
            7:          return 3;
            default:    return 4;
        endcase
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg(idx, data);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] mode_word,
                             input logic [CFG_DATA_W-1:0] rows,
                             input logic [CFG_DATA_W-1:0] cols);
        cfg_write(REG_TRIANGLE, mode_word);
        cfg_write(REG_ROWS, rows);
        cfg_write(REG_COLUMNS, cols);
        i_cfg_valid <= 1'b0;
    endtask

    // The block may still be summing a partial matrix after the last word,
    // so give it the full result latency before touching the registers.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_ratios.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_config();
        logic [CFG_DATA_W-1:0] mode_word;
        if ($urandom_range(0, 3) == 0) mode_word = 11'($urandom_range(0, 2047));
        else mode_word = 11'($urandom_range(0, 3));
        if ($urandom_range(0, 3) != 0) cfg_write(REG_TRIANGLE, mode_word);
        if ($urandom_range(0, 3) != 0) cfg_write(REG_ROWS, pick_dim());
        if ($urandom_range(0, 3) != 0) cfg_write(REG_COLUMNS, pick_dim());
        if ($urandom_range(0, 7) == 0) cfg_write(REG_UNUSED, 11'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        // Sizes come out of reset as one by one, so every word is a matrix.
        send_elem(32'h0000_0000, 32'h0000_0000);
        send_elem(32'h0001_0000, 32'hFFFF_0000);
        send_elem(32'h8000_0000, 32'h7FFF_FFFF);
        send_elem(32'h0000_0001, 32'h7FFF_FFFF);
        send_elem(32'h7FFF_FFFF, 32'h8000_0000);
        send_elem(32'h0003_0000, 32'h0001_0000);
        settle();
    endtask

    task automatic test_triangle_modes();
        configure({9'h1FF, TRI_LOWER}, 11'd2, 11'd2);
        send_matrix(4, 0);
        settle();
        configure({9'h1FF, TRI_UPPER}, 11'd2, 11'd2);
        send_matrix(4, 0);
        settle();
        configure({9'h000, TRI_SPARE}, 11'd2, 11'd2);
        send_matrix(4, 4);
        settle();
    endtask

    task automatic test_size_floor();
        configure({9'h000, TRI_FULL}, 11'd0, 11'd0);
        send_matrix(1, 0);
        settle();
    endtask

    task automatic test_restart_on_write();
        configure({9'h000, TRI_FULL}, 11'd2, 11'd2);
        send_matrix(3, 0);
        settle();
        // Unknown index leaves the partial matrix alone.
        cfg_write(REG_UNUSED, 11'h7FF);
        i_cfg_valid <= 1'b0;
        send_matrix(1, 0);
        send_matrix(2, 0);
        settle();
        // A real register write throws the partial matrix away.
        cfg_write(REG_COLUMNS, 11'd2);
        i_cfg_valid <= 1'b0;
        send_matrix(4, 0);
        settle();
    endtask

    task automatic test_random_regime(input int snd, input int stl, input int budget);
        int sent;
        int unsigned total;
        sent      = 0;
        send_pct  = snd;
        stall_pct = stl;
        while (sent < budget) begin
            settle();
            random_config();
            total = elems_per_matrix();
            repeat ($urandom_range(1, 4)) begin
                send_matrix(total, pick_flavor());
                sent += total;
            end
            if (total > 1 && $urandom_range(0, 7) == 0) begin
                total = $urandom_range(1, total - 1);
                send_matrix(total, 0);
                sent += total;
            end
        end
        settle();
    endtask

    task automatic test_back_pressure();
        send_pct  = 0;
        stall_pct = 0;
        configure({9'h000, TRI_FULL}, 11'd1, 11'd1);
        hold_req = 1'b1;
        send_matrix(48, 0);
        settle();
    endtask

    // A row count above the largest size acts as the largest size.
    task automatic test_largest_sizes();
        send_pct  = 0;
        stall_pct = 0;
        configure({9'h000, TRI_LOWER}, 11'd2047, 11'd1);
        send_matrix(elems_per_matrix(), pick_flavor());
        settle();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_pct  = 33;
        stall_pct = 76;
        test_reset_defaults();
        test_triangle_modes();
        test_size_floor();
        test_restart_on_write();
        test_random_regime(33, 76, 180);
        test_random_regime(76, 33, 180);
        test_random_regime(0, 0, 180);
        test_back_pressure();
        test_largest_sizes();
        if (pending_ratios.size() != 0) err_count++;
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
